[design/lis_pkg.sv]
// Shared types and constants for the longest increasing subsequence block.
// Holds the item structs and the sequencer state type; depends on nothing.
package lis_pkg;

  localparam int DATA_W = 32;
  localparam int LEN_W  = 11;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     first;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE,
    ST_EMIT
  } state_t;

endpackage

[design/longest_increasing_subsequence_length.sv]
// Top level of the longest strictly increasing subsequence length block.
// Depends on lis_pkg, lis_core and lis_ram; holds the result output register.
//
// Usage: in_data carries a signed value and a first flag; first starts a new
// sequence. Each accepted item yields one out_data item: the longest strictly
// increasing subsequence length of the sequence so far and a sticky overflow
// flag. Elements arriving once MAX_LEN are stored are dropped, overflow set.
// An item with elements stored before it is scanned, written and then emitted;
// a sequence-opening item skips the scan and a dropped one goes to emit directly.
// The single compare unit reads one stored element per cycle from the RAM
// read port; a new item is taken only once the last result is in the output register.
// in_ready is high only while the sequencer idles. The result waits in an
// output register; while out_ready is low the next item may still be taken
// and scanned, and it holds at the end of its scan until the register frees.
// Reset clears the sequence: the first items extend an empty sequence. The
// store needs no clearing pass; only entries of the current sequence are read.
module longest_increasing_subsequence_length #(
  parameter int MAX_LEN = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lis_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lis_pkg::out_t out_data
);

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int ENT_W  = lis_pkg::DATA_W + CNT_W;

  logic                 res_valid;
  logic                 res_ready;
  logic [CNT_W-1:0]     res_length;
  logic                 res_ovf;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;
  logic [lis_pkg::LEN_W+CNT_W-1:0] len_ext;

  logic                 out_valid_r;
  lis_pkg::out_t        out_data_r;

  lis_core #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .ADDR_W  (ADDR_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_length (res_length),
    .res_ovf    (res_ovf),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  lis_ram #(
    .DEPTH  (MAX_LEN),
    .WIDTH  (ENT_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign len_ext   = {lis_pkg::LEN_W'(0), res_length};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r.length   <= len_ext[lis_pkg::LEN_W-1:0];
      out_data_r.overflow <= res_ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/lis_ram.sv]
// Element store: one write port and one read port with registered read data.
// Generic; no package dependency.
module lis_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 43,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/lis_core.sv]
// Sequencer and shared compare unit: scans stored elements one per cycle.
// Depends on lis_pkg and drives the ports of lis_ram.
module lis_core #(
  parameter int MAX_LEN = 1024,
  parameter int CNT_W   = 11,
  parameter int ADDR_W  = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lis_pkg::in_t                         in_data,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [CNT_W-1:0]                     res_length,
  output logic                                 res_ovf,
  output logic                                 ram_we,
  output logic [ADDR_W-1:0]                    ram_waddr,
  output logic [lis_pkg::DATA_W+CNT_W-1:0]     ram_wdata,
  output logic                                 ram_re,
  output logic [ADDR_W-1:0]                    ram_raddr,
  input  logic [lis_pkg::DATA_W+CNT_W-1:0]     ram_rdata
);

  lis_pkg::state_t state_r, state_nxt;

  logic [lis_pkg::DATA_W-1:0] key_r;
  logic [CNT_W-1:0]           chain_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           best_r;
  logic                       ovf_r;
  logic [ADDR_W-1:0]          idx_r;
  logic                       rd_vld_r;

  logic [CNT_W-1:0]           cnt_eff;
  logic                       full_eff;
  logic                       accept;
  logic [ADDR_W-1:0]          last_idx;
  logic [lis_pkg::DATA_W-1:0] rd_key;
  logic [CNT_W-1:0]           rd_chain;
  logic                       extend;

  assign cnt_eff  = in_data.first ? '0 : count_r;
  assign full_eff = (cnt_eff == CNT_W'(MAX_LEN));
  assign accept   = in_valid && in_ready;
  assign last_idx = ADDR_W'(count_r - CNT_W'(1));
  assign rd_key   = ram_rdata[lis_pkg::DATA_W+CNT_W-1:CNT_W];
  assign rd_chain = ram_rdata[CNT_W-1:0];
  assign extend   = rd_vld_r && (rd_key < key_r) && (rd_chain >= chain_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lis_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (full_eff) begin
            state_nxt = lis_pkg::ST_EMIT;
          end else if (cnt_eff == '0) begin
            state_nxt = lis_pkg::ST_WRITE;
          end else begin
            state_nxt = lis_pkg::ST_SCAN;
          end
        end
      end
      lis_pkg::ST_SCAN: begin
        if (idx_r == last_idx) begin
          state_nxt = lis_pkg::ST_LAST;
        end
      end
      lis_pkg::ST_LAST:  state_nxt = lis_pkg::ST_WRITE;
      lis_pkg::ST_WRITE: state_nxt = lis_pkg::ST_EMIT;
      lis_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_nxt = lis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == lis_pkg::ST_IDLE);
    ram_re    = (state_r == lis_pkg::ST_SCAN);
    ram_we    = (state_r == lis_pkg::ST_WRITE);
    res_valid = (state_r == lis_pkg::ST_EMIT);
  end

  assign ram_raddr  = idx_r;
  assign ram_waddr  = count_r[ADDR_W-1:0];
  assign ram_wdata  = {key_r, chain_r};
  assign res_length = best_r;
  assign res_ovf    = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lis_pkg::ST_IDLE;
      count_r  <= '0;
      best_r   <= '0;
      ovf_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      if (accept) begin
        count_r <= cnt_eff;
        best_r  <= in_data.first ? '0 : best_r;
        ovf_r   <= (in_data.first ? 1'b0 : ovf_r) | full_eff;
      end
      if (ram_we) begin
        count_r <= count_r + CNT_W'(1);
        if (chain_r > best_r) begin
          best_r <= chain_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= {~in_data.value[lis_pkg::DATA_W-1], in_data.value[lis_pkg::DATA_W-2:0]};
      chain_r <= CNT_W'(1);
      idx_r   <= '0;
    end else begin
      if (ram_re) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
      if (extend) begin
        chain_r <= rd_chain + CNT_W'(1);
      end
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking bench for longest_increasing_subsequence_length.
// Scores each length/overflow item against an in-bench chain-length model.
// Depends on lis_pkg and the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 580;
  localparam int IDLE_PCT = 32;
  localparam logic signed [lis_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [lis_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lis_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lis_pkg::out_t out_data;

  int idle_pct = IDLE_PCT;
  int fail_count = 0;
  lis_pkg::out_t pending_lengths[$];

  logic signed [lis_pkg::DATA_W-1:0] seq_vals [STORE_DEPTH];
  int seq_chain [STORE_DEPTH];
  int seq_count = 0;
  int best_len = 0;
  bit seq_overflow = 1'b0;

  longest_increasing_subsequence_length #(
    .MAX_LEN(STORE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  function automatic lis_pkg::out_t lis_advance(lis_pkg::in_t item);
    logic signed [lis_pkg::DATA_W-1:0] v;
    int chain;
    lis_pkg::out_t res;
    v = item.value;
    if (item.first) begin
      seq_count = 0;
      best_len = 0;
      seq_overflow = 1'b0;
    end
    if (seq_count >= STORE_DEPTH) begin
      seq_overflow = 1'b1;
    end else begin
      chain = 1;
      for (int j = 0; j < seq_count; j++) begin
        if (seq_vals[j] < v && seq_chain[j] + 1 > chain) begin
          chain = seq_chain[j] + 1;
        end
      end
      seq_vals[seq_count] = v;
      seq_chain[seq_count] = chain;
      seq_count++;
      if (chain > best_len) begin
        best_len = chain;
      end
    end
    res.length = lis_pkg::LEN_W'(best_len);
    res.overflow = seq_overflow;
    return res;
  endfunction

  function automatic lis_pkg::in_t mk(logic signed [lis_pkg::DATA_W-1:0] v, logic f);
    lis_pkg::in_t item;
    item.value = v;
    item.first = f;
    return item;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input lis_pkg::in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_lengths.push_back(lis_advance(item));
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    lis_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lengths.size() == 0) begin
        $error("unexpected item: length=%0d overflow=%0b",
               out_data.length, out_data.overflow);
        fail_count++;
      end else begin
        want = pending_lengths.pop_front();
        if (out_data.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_data.length);
          fail_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_data.overflow);
          fail_count++;
        end
      end
    end
  end

  task automatic test_no_start_mark();
    send_item(mk(VAL_MIN, 1'b0));
    send_item(mk(0, 1'b0));
    send_item(mk(VAL_MAX, 1'b0));
    send_item(mk(VAL_MAX, 1'b0));
  endtask

  task automatic test_equal_values();
    send_item(mk(5, 1'b1));
    send_item(mk(5, 1'b0));
    send_item(mk(5, 1'b0));
    send_item(mk(6, 1'b0));
    send_item(mk(6, 1'b0));
    send_item(mk(4, 1'b0));
    send_item(mk(5, 1'b0));
  endtask

  task automatic test_extremes();
    send_item(mk(VAL_MAX, 1'b1));
    send_item(mk(VAL_MIN, 1'b0));
    send_item(mk(-1, 1'b0));
    send_item(mk(0, 1'b0));
    send_item(mk(1, 1'b0));
    send_item(mk(VAL_MAX, 1'b0));
  endtask

  task automatic test_restart();
    send_item(mk(10, 1'b1));
    send_item(mk(20, 1'b1));
    send_item(mk(30, 1'b1));
    send_item(mk(40, 1'b0));
    send_item(mk(-3, 1'b1));
  endtask

  // Fill the store with a strictly rising run, then push past it.
  task automatic test_store_full();
    logic signed [lis_pkg::DATA_W-1:0] v;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      v = VAL_MIN + (i << 22) + $urandom_range(32'h003F_FFFF);
      send_item(mk(v, i == 0));
    end
    send_item(mk(VAL_MAX, 1'b0));
    send_item(mk(VAL_MIN, 1'b0));
    send_item(mk($urandom, 1'b0));
    send_item(mk($urandom, 1'b1));
    send_item(mk(VAL_MAX, 1'b0));
  endtask

  task automatic test_random_sequences();
    int sent;
    int seq_len;
    int mode;
    int base;
    logic signed [lis_pkg::DATA_W-1:0] v;
    logic f;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seq_len = ($urandom_range(15) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
      mode = $urandom_range(4);
      base = $urandom;
      for (int k = 0; k < seq_len; k++) begin
        idle_pct = (sent >= 200 && sent < 320) ? 0 : IDLE_PCT;
        case (mode)
          0: v = $urandom;
          1: v = int'($urandom_range(16)) - 8;
          2: v = base + k * 1000 + int'($urandom_range(3000)) - 1500;
          3: v = base - k * 1000 + int'($urandom_range(3000)) - 1500;
          default: v = ($urandom_range(1) == 0) ? VAL_MIN + int'($urandom_range(3))
                                                : VAL_MAX - int'($urandom_range(3));
        endcase
        f = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
        send_item(mk(v, f));
        sent++;
      end
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_no_start_mark();
    test_equal_values();
    test_extremes();
    test_restart();
    test_store_full();
    test_random_sequences();
    in_valid = 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
